>>> hdl/sfr_pkg.sv
// Shared types and constants for the sorted run fence table.
// No dependencies; imported by the top level of the block.
package sfr_pkg;

    // Command codes carried on the cmd field.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_LOWER  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Status codes returned with every result item.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam int PORT_KEY_BITS = 64;
    localparam int BLOCK_BITS    = 32;
    localparam int IDX_OUT_BITS  = 11;
    localparam int CAP_BITS      = 11;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

endpackage

>>> hdl/sfr_run_mem.sv
// Run table memory: one write or read port, registered read data.
// Generic storage; no package dependencies.
module sfr_run_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Contents are undefined until written; the block only reads entries below its count.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/sorted_run_fence_table_core.sv
// Fence pointer table of one store level: run insert, point lookup, lower bound, clear.
// Insert and clear: the item is registered and executed in S_EXEC, and the result is
// registered; the next item can be taken at the edge that takes the result.
// Searches: at most P = ceil(log2(count + 1)) probes of the run memory, plus one more
// read when a lower bound lands on the next run.
// The single read port of the run memory sets the search rate: one probe per cycle.
// Reset (rst_n low, asynchronous) empties the level and sets capacity to 1024; the run
// memory is not cleared. Results cannot be stalled: done is high for one cycle per item.
module sorted_run_fence_table_core #(
    parameter int MAX_RUNS = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 level_capacity_we,
    input  logic [sfr_pkg::CAP_BITS-1:0]         level_capacity,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           cmd,
    input  logic [sfr_pkg::PORT_KEY_BITS-1:0]    key_low,
    input  logic [sfr_pkg::PORT_KEY_BITS-1:0]    key_high,
    input  logic [sfr_pkg::BLOCK_BITS-1:0]       block_number,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [sfr_pkg::IDX_OUT_BITS-1:0]     run_index,
    output logic [sfr_pkg::BLOCK_BITS-1:0]       run_block,
    output logic [sfr_pkg::IDX_OUT_BITS-1:0]     run_count,
    output logic [sfr_pkg::PORT_KEY_BITS-1:0]    level_min,
    output logic [sfr_pkg::PORT_KEY_BITS-1:0]    level_max
);

    import sfr_pkg::*;

    // Index width addresses the run memory; count width can also hold MAX_RUNS itself.
    localparam int IW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int XW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int EW = 2 * KEY_BITS + BLOCK_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_NEXT
    } state_t;

    state_t state_reg, state_next;

    // Level state and capacity register.
    logic [CAP_BITS-1:0] cap_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_BITS-1:0] min_reg, min_next;
    logic [KEY_BITS-1:0] max_reg, max_next;

    // The item being worked on.
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   klo_reg, klo_next;
    logic [KEY_BITS-1:0]   khi_reg, khi_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;

    // Binary search window: lo inclusive, hx exclusive, mid the probe in flight.
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hx_reg, hx_next;
    logic [IW-1:0] mid_reg, mid_next;

    // Registered result ports.
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [IDX_OUT_BITS-1:0] ridx_reg, ridx_next;
    logic [BLOCK_BITS-1:0]   rblk_reg, rblk_next;

    // Run memory port.
    logic          mem_we;
    logic [IW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] mem_rdata;

    logic [KEY_BITS-1:0]   ent_start;
    logic [KEY_BITS-1:0]   ent_end;
    logic [BLOCK_BITS-1:0] ent_blk;
    logic                  above;
    logic                  below;
    logic                  full;
    logic                  reject;
    logic [CW:0]           mid_sum;
    logic [IW-1:0]         mid_calc;
    logic [KEY_BITS-1:0]   widen_lo;
    logic [KEY_BITS-1:0]   widen_hi;

    sfr_run_mem #(
        .DEPTH (MAX_RUNS),
        .WIDTH (EW)
    ) u_run_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign ent_start = mem_rdata[EW-1 -: KEY_BITS];
    assign ent_end   = mem_rdata[BLOCK_BITS +: KEY_BITS];
    assign ent_blk   = mem_rdata[BLOCK_BITS-1:0];
    assign mem_wdata = {klo_reg, khi_reg, blk_reg};

    // The probed run lies above or below the searched key.
    assign above = ent_start > klo_reg;
    assign below = ent_end < klo_reg;

    // The level is full when count reaches the smaller of capacity and MAX_RUNS.
    assign full = (XW'(count_reg) >= XW'(MAX_RUNS)) || (XW'(count_reg) >= XW'(cap_reg));

    // Empty levels never match; point lookups also reject keys outside the level range.
    assign reject = (count_reg == '0) ||
                    ((cmd_reg == CMD_LOOKUP) && ((min_reg > klo_reg) || (max_reg < klo_reg)));

    // The insert widens the level range by both the start and the end key.
    assign widen_lo = (klo_reg < khi_reg) ? klo_reg : khi_reg;
    assign widen_hi = (klo_reg > khi_reg) ? klo_reg : khi_reg;

    // Midpoint of the next window; the window is non-empty whenever this is used.
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hx_next} - (CW + 1)'(1);
    assign mid_calc = IW'(mid_sum >> 1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        cmd_next    = cmd_reg;
        klo_next    = klo_reg;
        khi_next    = khi_reg;
        blk_next    = blk_reg;
        lo_next     = lo_reg;
        hx_next     = hx_reg;
        mid_next    = mid_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        ridx_next   = ridx_reg;
        rblk_next   = rblk_reg;
        mem_we      = 1'b0;
        mem_addr    = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(cmd);
                    klo_next   = key_low[KEY_BITS-1:0];
                    khi_next   = key_high[KEY_BITS-1:0];
                    blk_next   = block_number;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (full)
                        begin
                            status_next = ST_FULL;
                            ridx_next   = '0;
                            rblk_next   = '0;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_addr    = count_reg[IW-1:0];
                            status_next = ST_DONE;
                            ridx_next   = IDX_OUT_BITS'(count_reg);
                            rblk_next   = blk_reg;
                            count_next  = count_reg + CW'(1);
                            if (widen_lo < min_reg)
                            begin
                                min_next = widen_lo;
                            end
                            if (widen_hi > max_reg)
                            begin
                                max_next = widen_hi;
                            end
                        end
                    end

                    CMD_CLEAR:
                    begin
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                        status_next = ST_DONE;
                        ridx_next   = '0;
                        rblk_next   = '0;
                        count_next  = '0;
                        min_next    = '1;
                        max_next    = '0;
                    end

                    CMD_LOOKUP, CMD_LOWER:
                    begin
                        if (reject)
                        begin
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                            status_next = ST_NOT_FOUND;
                            ridx_next   = '0;
                            rblk_next   = '0;
                        end
                        else
                        begin
                            // Open the window over all runs and issue the first probe.
                            lo_next    = '0;
                            hx_next    = count_reg;
                            mid_next   = mid_calc;
                            mem_addr   = mid_calc;
                            state_next = S_PROBE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_PROBE:
            begin
                if (!above && !below)
                begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    status_next = ST_FOUND;
                    ridx_next   = IDX_OUT_BITS'(mid_reg);
                    rblk_next   = ent_blk;
                end
                else
                begin
                    if (above)
                    begin
                        hx_next = CW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CW'(mid_reg) + CW'(1);
                    end

                    priority if (lo_next < hx_next)
                    begin
                        mid_next = mid_calc;
                        mem_addr = mid_calc;
                    end
                    else if ((cmd_reg == CMD_LOWER) && above)
                    begin
                        // The probed run is the first one past the key.
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                        status_next = ST_FOUND;
                        ridx_next   = IDX_OUT_BITS'(mid_reg);
                        rblk_next   = ent_blk;
                    end
                    else if ((cmd_reg == CMD_LOWER) &&
                             ((CW'(mid_reg) + CW'(1)) < count_reg))
                    begin
                        // The key falls past the probed run; fetch the following one.
                        mid_next   = mid_reg + IW'(1);
                        mem_addr   = mid_reg + IW'(1);
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                        status_next = ST_NOT_FOUND;
                        ridx_next   = '0;
                        rblk_next   = '0;
                    end
                end
            end

            S_NEXT:
            begin
                done_next   = 1'b1;
                state_next  = S_IDLE;
                status_next = ST_FOUND;
                ridx_next   = IDX_OUT_BITS'(mid_reg);
                rblk_next   = ent_blk;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            if (level_capacity_we)
            begin
                cap_reg <= level_capacity;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        klo_reg    <= klo_next;
        khi_reg    <= khi_next;
        blk_reg    <= blk_next;
        lo_reg     <= lo_next;
        hx_reg     <= hx_next;
        mid_reg    <= mid_next;
        status_reg <= status_next;
        ridx_reg   <= ridx_next;
        rblk_reg   <= rblk_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign run_index = ridx_reg;
    assign run_block = rblk_reg;
    assign run_count = IDX_OUT_BITS'(count_reg);
    assign level_min = PORT_KEY_BITS'(min_reg);
    assign level_max = PORT_KEY_BITS'(max_reg);

endmodule

>>> tb/sorted_run_fence_table_core_test.sv
// Self-checking testbench for the sorted run fence table core: inserts, lookups and clears.
// Depends on sfr_pkg for command and status codes and on sorted_run_fence_table_core.
`timescale 1ns / 1ps

module sorted_run_fence_table_core_test;

    import sfr_pkg::*;

    localparam int          TABLE_DEPTH  = 1024;
    // Runs loaded by the fill test; the capacity is set to match so the level fills up.
    localparam int          FILL_RUNS    = 200;
    localparam logic [63:0] KEY_ALL      = {64{1'b1}};
    // Longest run of idle cycles the sender inserts before one item.
    localparam int          MAX_GAP      = 200;
    // Far longer than any search or any idle gap of the sender, so only a hang reaches it.
    localparam int          STALL_LIMIT  = 4000;
    // Cycles to watch the outputs after the last result has come in.
    localparam int          DRAIN_CYCLES = 32;

    // One expected result item, laid out like the result ports.
    typedef struct {
        status_t                 status;
        logic [IDX_OUT_BITS-1:0] run_index;
        logic [BLOCK_BITS-1:0]   run_block;
        logic [IDX_OUT_BITS-1:0] run_count;
        logic [63:0]             level_min;
        logic [63:0]             level_max;
    } fence_result_t;

    logic                          clk               = 1'b0;
    logic                          rst_n             = 1'b0;
    logic                          level_capacity_we = 1'b0;
    logic [CAP_BITS-1:0]           level_capacity    = CAP_RESET;
    logic                          start             = 1'b0;
    logic                          busy;
    logic [1:0]                    cmd               = CMD_INSERT;
    logic [PORT_KEY_BITS-1:0]      key_low           = '0;
    logic [PORT_KEY_BITS-1:0]      key_high          = '0;
    logic [BLOCK_BITS-1:0]         block_number      = '0;
    logic                          done;
    logic [1:0]                    status;
    logic [IDX_OUT_BITS-1:0]       run_index;
    logic [BLOCK_BITS-1:0]         run_block;
    logic [IDX_OUT_BITS-1:0]       run_count;
    logic [PORT_KEY_BITS-1:0]      level_min;
    logic [PORT_KEY_BITS-1:0]      level_max;

    // Shadow copy of the level: the runs held, their key span and the capacity register.
    logic [63:0]         run_start_key [TABLE_DEPTH];
    logic [63:0]         run_end_key   [TABLE_DEPTH];
    logic [31:0]         run_block_no  [TABLE_DEPTH];
    int                  run_total;
    logic [63:0]         span_min;
    logic [63:0]         span_max;
    logic [CAP_BITS-1:0] capacity_setting;

    // Results predicted for accepted items, oldest first.
    fence_result_t pending_results [$];
    fence_result_t oldest_expected;

    int idle_pct;
    int mismatch_count;
    int item_total;
    int full_replies;
    int cmd_seen [4];
    int stall_cycles;

    sorted_run_fence_table_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .level_capacity_we (level_capacity_we),
        .level_capacity    (level_capacity),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .key_low           (key_low),
        .key_high          (key_high),
        .block_number      (block_number),
        .done              (done),
        .status            (status),
        .run_index         (run_index),
        .run_block         (run_block),
        .run_count         (run_count),
        .level_min         (level_min),
        .level_max         (level_max)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Binary search over the shadow runs. A miss gives -1, or, when the next run is
    // wanted, the run suggested by the last probe: the probed run itself if it starts
    // above the key, the one after it if it ends below the key and is not the last.
    function automatic int locate_run(input logic [63:0] key, input bit want_next);
        int lo;
        int hi;
        int mid;
        bit above;
        bit below;
        lo    = 0;
        hi    = run_total - 1;
        mid   = 0;
        above = 1'b0;
        below = 1'b0;
        while (lo <= hi)
        begin
            mid   = (lo + hi) / 2;
            above = run_start_key[mid] > key;
            below = run_end_key[mid] < key;
            if (!above && !below)
                return mid;
            if (above)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (!want_next)
            return -1;
        if (above)
            return mid;
        if (below && mid < run_total - 1)
            return mid + 1;
        return -1;
    endfunction

    // Applies one item to the shadow level and returns the result the block must give.
    function automatic fence_result_t predict_fence_result(input cmd_t c,
                                                           input logic [63:0] klo,
                                                           input logic [63:0] khi,
                                                           input logic [31:0] blk);
        fence_result_t r;
        int            limit;
        int            hit;
        r.status    = ST_DONE;
        r.run_index = '0;
        r.run_block = '0;
        // The register can exceed the table depth; the table depth then rules.
        limit = (int'(capacity_setting) < TABLE_DEPTH) ? int'(capacity_setting) : TABLE_DEPTH;
        case (c)
            CMD_INSERT:
            begin
                if (run_total >= limit)
                    r.status = ST_FULL;
                else
                begin
                    run_start_key[run_total] = klo;
                    run_end_key[run_total]   = khi;
                    run_block_no[run_total]  = blk;
                    // Both ends widen the span, even for a run given end first.
                    if (span_min > klo) span_min = klo;
                    if (span_max < klo) span_max = klo;
                    if (span_min > khi) span_min = khi;
                    if (span_max < khi) span_max = khi;
                    r.run_index = run_total[IDX_OUT_BITS-1:0];
                    r.run_block = blk;
                    run_total++;
                end
            end
            CMD_CLEAR:
            begin
                run_total = 0;
                span_min  = KEY_ALL;
                span_max  = '0;
            end
            default:
            begin
                // A point lookup rejects keys outside the level span before searching.
                if (c == CMD_LOOKUP && (run_total == 0 || span_min > klo || span_max < klo))
                    hit = -1;
                else
                    hit = locate_run(klo, c == CMD_LOWER);
                if (hit >= 0 && hit < run_total)
                begin
                    r.status    = ST_FOUND;
                    r.run_index = hit[IDX_OUT_BITS-1:0];
                    r.run_block = run_block_no[hit];
                end
                else
                    r.status = ST_NOT_FOUND;
            end
        endcase
        r.run_count = run_total[IDX_OUT_BITS-1:0];
        r.level_min = span_min;
        r.level_max = span_max;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Every call starts at a rising edge. The sender may first go idle for a random
    // number of cycles; start stays high from the previous item when there is no gap,
    // so it never gets two assignments in one step.
    task automatic send_item(input cmd_t c, input logic [63:0] klo, input logic [63:0] khi,
                             input logic [31:0] blk);
        int            gap;
        fence_result_t r;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            if (gap == 0)
                start <= 1'b0;
            gap++;
            @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        key_low      <= klo;
        key_high     <= khi;
        block_number <= blk;
        // The item is taken at the first edge where busy was low with start high.
        do
            @(posedge clk);
        while (busy);
        r = predict_fence_result(c, klo, khi, blk);
        pending_results.push_back(r);
        item_total++;
        cmd_seen[int'(c)]++;
        if (r.status == ST_FULL)
            full_replies++;
    endtask

    // Every item gives a result, so the block is idle once nothing is pending.
    task automatic set_level_capacity(input logic [CAP_BITS-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        level_capacity_we <= 1'b1;
        level_capacity    <= value;
        @(posedge clk);
        level_capacity_we <= 1'b0;
        capacity_setting   = value;
    endtask

    // Hand-picked items: empty level, the key extremes, hits, gaps, next-run answers,
    // a lower bound past the last run, an out-of-order insert and clears.
    task automatic test_directed_edges();
        idle_pct = 0;
        send_item(CMD_LOOKUP, 64'd0, KEY_ALL, 32'hFFFF_FFFF);
        send_item(CMD_LOWER, KEY_ALL, 64'd0, 32'd0);
        send_item(CMD_INSERT, 64'd5, 64'd8, 32'd0);
        send_item(CMD_LOWER, 64'd9, KEY_ALL, 32'd0);
        send_item(CMD_LOOKUP, 64'd4, 64'd0, 32'd0);
        send_item(CMD_LOWER, 64'd4, 64'd0, 32'd0);
        send_item(CMD_LOOKUP, 64'd8, 64'd0, 32'd0);
        send_item(CMD_INSERT, 64'd20, 64'd30, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 64'd1000, KEY_ALL - 64'd2, 32'h5A5A_5A5A);
        send_item(CMD_INSERT, KEY_ALL - 64'd1, KEY_ALL, 32'hA5A5_A5A5);
        send_item(CMD_LOOKUP, 64'd25, 64'd0, 32'd0);
        send_item(CMD_LOOKUP, 64'd15, 64'd0, 32'd0);
        send_item(CMD_LOWER, 64'd15, 64'd0, 32'd0);
        send_item(CMD_LOWER, 64'd500, 64'd0, 32'd0);
        send_item(CMD_LOOKUP, KEY_ALL, KEY_ALL, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, KEY_ALL - 64'd2, 64'd0, 32'd0);
        // Out of order: the span still widens down to zero.
        send_item(CMD_INSERT, 64'd0, 64'd0, 32'h0000_0001);
        send_item(CMD_LOOKUP, 64'd0, 64'd0, 32'd0);
        send_item(CMD_CLEAR, KEY_ALL, KEY_ALL, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 64'd0, 64'd0, 32'd0);
        send_item(CMD_INSERT, 64'd0, KEY_ALL, 32'hFFFF_FFFF);
        send_item(CMD_LOWER, 64'd12345, 64'd0, 32'd0);
        send_item(CMD_CLEAR, 64'd0, 64'd0, 32'd0);
    endtask

    // Capacity of zero, of one, lowered below the number of runs held, and above the
    // table depth.
    task automatic test_capacity_limits();
        idle_pct = 0;
        set_level_capacity(11'd0);
        send_item(CMD_INSERT, 64'd10, 64'd20, 32'h1234_5678);
        send_item(CMD_LOOKUP, 64'd15, 64'd0, 32'd0);
        send_item(CMD_LOWER, 64'd15, 64'd0, 32'd0);
        set_level_capacity(11'd1);
        send_item(CMD_INSERT, 64'd10, 64'd20, 32'h1234_5678);
        send_item(CMD_INSERT, 64'd30, 64'd40, 32'h8765_4321);
        set_level_capacity(11'd3);
        send_item(CMD_CLEAR, 64'd0, 64'd0, 32'd0);
        send_item(CMD_INSERT, 64'd100, 64'd199, 32'd1);
        send_item(CMD_INSERT, 64'd200, 64'd299, 32'd2);
        send_item(CMD_INSERT, 64'd300, 64'd399, 32'd3);
        // Runs already held stay searchable after the limit drops below them.
        set_level_capacity(11'd1);
        send_item(CMD_INSERT, 64'd400, 64'd499, 32'd4);
        send_item(CMD_LOOKUP, 64'd350, 64'd0, 32'd0);
        send_item(CMD_LOWER, 64'd150, 64'd0, 32'd0);
        set_level_capacity(11'd2047);
        send_item(CMD_INSERT, 64'd400, 64'd499, 32'd4);
        send_item(CMD_LOOKUP, 64'd499, 64'd0, 32'd0);
        send_item(CMD_CLEAR, 64'd0, 64'd0, 32'd0);
    endtask

    // Fills the level up to its capacity, so searches run deep, then refuses one more.
    task automatic test_full_table();
        logic [63:0] starts [$];
        logic [63:0] ends [$];
        logic [63:0] s;
        logic [63:0] e;
        int          j;
        idle_pct = 0;
        set_level_capacity(11'(FILL_RUNS));
        send_item(CMD_CLEAR, 64'd0, 64'd0, 32'd0);
        for (int i = 0; i < FILL_RUNS; i++)
        begin
            // Each run lives in its own 2^54 slice of the key space.
            s = (64'(i) << 54) | (rand_key() & ((64'd1 << 53) - 1));
            e = s + (rand_key() & ((64'd1 << 52) - 1));
            starts.push_back(s);
            ends.push_back(e);
            send_item(CMD_INSERT, s, e, $urandom);
        end
        send_item(CMD_INSERT, KEY_ALL, KEY_ALL, $urandom);
        for (int i = 0; i < 60; i++)
        begin
            j = $urandom_range(FILL_RUNS - 1);
            case ($urandom_range(3))
                0:       s = starts[j];
                1:       s = ends[j] + 64'd1;
                2:       s = starts[j] + (rand_key() % (ends[j] - starts[j] + 64'd1));
                default: s = rand_key();
            endcase
            send_item($urandom_range(1) ? CMD_LOOKUP : CMD_LOWER, s, rand_key(), $urandom);
        end
        send_item(CMD_CLEAR, rand_key(), rand_key(), $urandom);
    endtask

    // Mostly well-formed traffic: usually a clear, a batch of ascending runs with random
    // spacing, then searches aimed at run edges, run interiors, the gaps around them and
    // random keys. About one search in ten is noise with random fields, out-of-order
    // inserts among them. The phase stops as soon as its item budget is spent.
    task automatic test_random_traffic(input int pct, input logic [CAP_BITS-1:0] cap,
                                       input int budget);
        logic [63:0] starts [$];
        logic [63:0] ends [$];
        logic [63:0] cursor;
        logic [63:0] mask;
        logic [63:0] room;
        logic [63:0] s;
        logic [63:0] e;
        int          first_item;
        int          n;
        int          m;
        int          j;
        int          shift;
        set_level_capacity(cap);
        idle_pct   = pct;
        first_item = item_total;
        while (item_total - first_item < budget)
        begin
            starts.delete();
            ends.delete();
            if ($urandom_range(4) != 0)
                send_item(CMD_CLEAR, rand_key(), rand_key(), $urandom);
            n     = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
            shift = $urandom_range(1, 56);
            mask  = (64'd1 << shift) - 64'd1;
            // Leave enough room above the first run that the batch cannot wrap.
            room   = 64'(2 * n + 2) << shift;
            cursor = rand_key() % (KEY_ALL - room);
            if ($urandom_range(7) == 0)
                cursor = KEY_ALL - room;
            for (int i = 0; i < n && item_total - first_item < budget; i++)
            begin
                s = (i == 0) ? cursor : cursor + (rand_key() & mask) + 64'd1;
                e = ($urandom_range(5) == 0) ? s : s + (rand_key() & mask);
                starts.push_back(s);
                ends.push_back(e);
                send_item(CMD_INSERT, s, e, $urandom);
                cursor = e;
            end
            m = $urandom_range(n, 3 * n + 2);
            for (int i = 0; i < m && item_total - first_item < budget; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(cmd_t'($urandom_range(3)), rand_key(), rand_key(), $urandom);
                else
                begin
                    j = $urandom_range(n - 1);
                    case ($urandom_range(7))
                        0:       s = starts[j];
                        1:       s = ends[j];
                        2:       s = starts[j] + (rand_key() % (ends[j] - starts[j] + 64'd1));
                        3:       s = starts[j] - 64'd1;
                        4:       s = ends[j] + 64'd1;
                        5:       s = rand_key();
                        6:       s = $urandom_range(1) ? KEY_ALL : 64'd0;
                        default: s = ends[n-1] + (rand_key() & mask) + 64'd1;
                    endcase
                    send_item($urandom_range(1) ? CMD_LOOKUP : CMD_LOWER, s, rand_key(),
                              $urandom);
                end
            end
        end
    endtask

    // Result checker: the strobe and result ports are sampled at the edge that ends the
    // strobe cycle, and each result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item pending", {62'd0, status}, 64'd0);
            else
            begin
                oldest_expected = pending_results.pop_front();
                if (status !== oldest_expected.status)
                    report_mismatch("status", 64'(status), 64'(oldest_expected.status));
                if (run_index !== oldest_expected.run_index)
                    report_mismatch("run_index", 64'(run_index),
                                    64'(oldest_expected.run_index));
                if (run_block !== oldest_expected.run_block)
                    report_mismatch("run_block", 64'(run_block),
                                    64'(oldest_expected.run_block));
                if (run_count !== oldest_expected.run_count)
                    report_mismatch("run_count", 64'(run_count),
                                    64'(oldest_expected.run_count));
                if (level_min !== oldest_expected.level_min)
                    report_mismatch("level_min", level_min, oldest_expected.level_min);
                if (level_max !== oldest_expected.level_max)
                    report_mismatch("level_max", level_max, oldest_expected.level_max);
            end
        end
    end

    // Watchdog: any accepted item or result restarts the count of quiet cycles.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] Timeout: nothing accepted for %0d cycles", $realtime, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        mismatch_count   = 0;
        item_total       = 0;
        full_replies     = 0;
        cmd_seen         = '{0, 0, 0, 0};
        idle_pct         = 0;
        run_total        = 0;
        span_min         = KEY_ALL;
        span_max         = '0;
        capacity_setting = CAP_RESET;

        // Single reset at the start; the level comes up empty with capacity 1024.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_edges();
        test_capacity_limits();
        test_full_table();
        test_random_traffic(0, 11'd1024, 62);
        test_random_traffic(83, 11'($urandom_range(1, 24)), 62);
        test_random_traffic(0, 11'd2047, 62);
        test_random_traffic(29, 11'($urandom_range(1, 1024)), 62);

        // Drain: wait for the last results, then watch the outputs a little longer.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d inserts (%0d refused as full), %0d point lookups,",
                 item_total, cmd_seen[int'(CMD_INSERT)], full_replies,
                 cmd_seen[int'(CMD_LOOKUP)]);
        $display("%0d lower-bound searches, %0d clears; capacities 0 to 2047, a filled level.",
                 cmd_seen[int'(CMD_LOWER)], cmd_seen[int'(CMD_CLEAR)]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
